// ===== hw/rtl/lsoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsoa_pkg
// Shared types and constants for the lidar sector obstacle avoider.
// ----------------------------------------------------------------------------
package lsoa_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int SPEED_W     = 10;
  localparam int DIST_W      = 16;
  localparam int SCAN_LEN_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_LENGTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_DISTANCE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKUP_DISTANCE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_DISTANCE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_SECTOR   = 3'd4;

  localparam logic [SCAN_LEN_W-1:0] SCAN_LENGTH_RESET     = 13'd360;
  localparam logic [DIST_W-1:0]     STOP_DISTANCE_RESET   = 16'd500;
  localparam logic [DIST_W-1:0]     BACKUP_DISTANCE_RESET = 16'd250;
  localparam logic [DIST_W-1:0]     SIDE_DISTANCE_RESET   = 16'd300;
  localparam logic [DIST_W-1:0]     EMPTY_SECTOR_RESET    = 16'd5000;

  localparam logic signed [SPEED_W-1:0] LIN_BACKUP  = -10'sd150;
  localparam logic signed [SPEED_W-1:0] LIN_STOP    = 10'sd0;
  localparam logic signed [SPEED_W-1:0] LIN_VEER    = 10'sd100;
  localparam logic signed [SPEED_W-1:0] LIN_FORWARD = 10'sd300;
  localparam logic signed [SPEED_W-1:0] ANG_NONE    = 10'sd0;
  localparam logic signed [SPEED_W-1:0] ANG_SPIN_L  = 10'sd500;
  localparam logic signed [SPEED_W-1:0] ANG_SPIN_R  = -10'sd500;
  localparam logic signed [SPEED_W-1:0] ANG_VEER_L  = 10'sd300;
  localparam logic signed [SPEED_W-1:0] ANG_VEER_R  = -10'sd300;

  typedef enum logic [2:0] {
    ACT_BACKUP     = 3'd0,
    ACT_SPIN_LEFT  = 3'd1,
    ACT_SPIN_RIGHT = 3'd2,
    ACT_VEER_LEFT  = 3'd3,
    ACT_VEER_RIGHT = 3'd4,
    ACT_FORWARD    = 3'd5
  } action_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lsoa_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsoa_sample_if
// Lidar sample channel: one range reading per beat.
// ----------------------------------------------------------------------------
interface lsoa_sample_if #(
  parameter int RANGE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_mm;
  logic                  not_finite;

  modport source (output valid, output range_mm, output not_finite, input ready);
  modport sink   (input valid, input range_mm, input not_finite, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lsoa_command_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsoa_command_if
// Drive command channel: one command and three sector minima per beat.
// ----------------------------------------------------------------------------
interface lsoa_command_if;
  logic                               valid;
  logic                               ready;
  logic signed [lsoa_pkg::SPEED_W-1:0] linear_speed;
  logic signed [lsoa_pkg::SPEED_W-1:0] angular_speed;
  lsoa_pkg::action_t                  action;
  logic [lsoa_pkg::DIST_W-1:0]        front_min_mm;
  logic [lsoa_pkg::DIST_W-1:0]        left_min_mm;
  logic [lsoa_pkg::DIST_W-1:0]        right_min_mm;

  modport source (
    output valid, output linear_speed, output angular_speed, output action,
    output front_min_mm, output left_min_mm, output right_min_mm, input ready
  );
  modport sink (
    input valid, input linear_speed, input angular_speed, input action,
    input front_min_mm, input left_min_mm, input right_min_mm, output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/lidar_sector_obstacle_avoider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_sector_obstacle_avoider
// Per-scan sector minima of lidar ranges and a reactive drive command.
// ----------------------------------------------------------------------------
// Takes one range sample per clock on the samples channel, folds it into the
// right, front or left sector minimum by its position in the scan, and on the
// last sample of a scan presents one beat on the commands channel in the next
// cycle. The input is stalled for as long as a command waits and
// is not taken; a command taken in the same cycle frees the register, so a
// back-to-back stream runs at one sample per clock when the commands channel
// is ready. The sector bounds are recomputed from scan_length at the register
// write, so a write is registered before it affects the next sample.
// ----------------------------------------------------------------------------
module lidar_sector_obstacle_avoider #(
  parameter int MAX_SCAN   = 4096,
  parameter int RANGE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lsoa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lsoa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  lsoa_sample_if.sink                             samples,
  lsoa_command_if.source                          commands
);
  import lsoa_pkg::*;

  localparam int POS_W = (MAX_SCAN > 1) ? $clog2(MAX_SCAN) : 1;
  localparam int LEN_W = ($clog2(MAX_SCAN + 1) > SCAN_LEN_W) ?
                         $clog2(MAX_SCAN + 1) : SCAN_LEN_W;
  localparam int CW    = (RANGE_BITS > DIST_W) ? RANGE_BITS : DIST_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SCAN);

  // configuration
  logic [POS_W-1:0]  bound_1;
  logic [POS_W-1:0]  bound_3;
  logic [POS_W-1:0]  bound_5;
  logic [POS_W-1:0]  bound_7;
  logic [POS_W-1:0]  last_pos;
  logic [DIST_W-1:0] stop_dist;
  logic [DIST_W-1:0] backup_dist;
  logic [DIST_W-1:0] side_dist;
  logic [DIST_W-1:0] empty_dist;

  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W+2:0] len_x3;
  logic [LEN_W+2:0] len_x5;
  logic [LEN_W+2:0] len_x7;
  logic             len_load;

  always_comb begin
    len_raw = rst ? LEN_W'(SCAN_LENGTH_RESET) : LEN_W'(cfg_wdata[SCAN_LEN_W-1:0]);
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = len_raw;
    end
    len_x3   = (LEN_W+3)'(len_eff) + ((LEN_W+3)'(len_eff) << 1);
    len_x5   = (LEN_W+3)'(len_eff) + ((LEN_W+3)'(len_eff) << 2);
    len_x7   = ((LEN_W+3)'(len_eff) << 3) - (LEN_W+3)'(len_eff);
    len_load = rst || (cfg_we && cfg_index == CFG_SCAN_LENGTH);
  end

  always_ff @(posedge clk) begin
    if (len_load) begin
      bound_1  <= POS_W'(len_eff >> 3);
      bound_3  <= POS_W'(len_x3 >> 3);
      bound_5  <= POS_W'(len_x5 >> 3);
      bound_7  <= POS_W'(len_x7 >> 3);
      last_pos <= POS_W'(len_eff - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_dist   <= STOP_DISTANCE_RESET;
      backup_dist <= BACKUP_DISTANCE_RESET;
      side_dist   <= SIDE_DISTANCE_RESET;
      empty_dist  <= EMPTY_SECTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STOP_DISTANCE:   stop_dist   <= cfg_wdata;
        CFG_BACKUP_DISTANCE: backup_dist <= cfg_wdata;
        CFG_SIDE_DISTANCE:   side_dist   <= cfg_wdata;
        CFG_EMPTY_SECTOR:    empty_dist  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // scan state
  logic [POS_W-1:0]      pos;
  logic [2:0]            seen;
  logic [RANGE_BITS-1:0] right_nearest;
  logic [RANGE_BITS-1:0] front_nearest;
  logic [RANGE_BITS-1:0] left_nearest;

  logic                  fire;
  logic                  at_last;
  logic                  good;
  logic                  hit_r;
  logic                  hit_f;
  logic                  hit_l;
  logic [2:0]            seen_next;
  logic [RANGE_BITS-1:0] right_next;
  logic [RANGE_BITS-1:0] front_next;
  logic [RANGE_BITS-1:0] left_next;

  assign samples.ready = !commands.valid || commands.ready;
  assign fire          = samples.valid && samples.ready;
  assign at_last       = pos >= last_pos;

  always_comb begin
    good  = !samples.not_finite && samples.range_mm != '0;
    hit_r = good && pos >= bound_1 && pos < bound_3;
    hit_f = good && pos >= bound_3 && pos < bound_5;
    hit_l = good && pos >= bound_5 && pos < bound_7;

    seen_next  = seen | {hit_l, hit_f, hit_r};
    right_next = (hit_r && (!seen[0] || samples.range_mm < right_nearest)) ?
                 samples.range_mm : right_nearest;
    front_next = (hit_f && (!seen[1] || samples.range_mm < front_nearest)) ?
                 samples.range_mm : front_nearest;
    left_next  = (hit_l && (!seen[2] || samples.range_mm < left_nearest)) ?
                 samples.range_mm : left_nearest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      seen <= '0;
    end else if (fire) begin
      pos  <= at_last ? '0 : pos + POS_W'(1);
      seen <= at_last ? '0 : seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      right_nearest <= right_next;
      front_nearest <= front_next;
      left_nearest  <= left_next;
    end
  end

  // decision
  logic [CW-1:0]               fr;
  logic [CW-1:0]               lf;
  logic [CW-1:0]               rt;
  logic signed [SPEED_W-1:0]   lin_next;
  logic signed [SPEED_W-1:0]   ang_next;
  action_t                     act_next;

  always_comb begin
    fr = seen_next[1] ? CW'(front_next) : CW'(empty_dist);
    lf = seen_next[2] ? CW'(left_next)  : CW'(empty_dist);
    rt = seen_next[0] ? CW'(right_next) : CW'(empty_dist);
    if (fr < CW'(backup_dist)) begin
      lin_next = LIN_BACKUP;
      ang_next = ANG_NONE;
      act_next = ACT_BACKUP;
    end else if (fr < CW'(stop_dist)) begin
      lin_next = LIN_STOP;
      if (lf > rt) begin
        ang_next = ANG_SPIN_L;
        act_next = ACT_SPIN_LEFT;
      end else begin
        ang_next = ANG_SPIN_R;
        act_next = ACT_SPIN_RIGHT;
      end
    end else if (rt < CW'(side_dist)) begin
      lin_next = LIN_VEER;
      ang_next = ANG_VEER_L;
      act_next = ACT_VEER_LEFT;
    end else if (lf < CW'(side_dist)) begin
      lin_next = LIN_VEER;
      ang_next = ANG_VEER_R;
      act_next = ACT_VEER_RIGHT;
    end else begin
      lin_next = LIN_FORWARD;
      ang_next = ANG_NONE;
      act_next = ACT_FORWARD;
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      commands.valid <= 1'b0;
    end else if (fire && at_last) begin
      commands.valid <= 1'b1;
    end else if (commands.ready) begin
      commands.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && at_last) begin
      commands.linear_speed  <= lin_next;
      commands.angular_speed <= ang_next;
      commands.action        <= act_next;
      commands.front_min_mm  <= fr[DIST_W-1:0];
      commands.left_min_mm   <= lf[DIST_W-1:0];
      commands.right_min_mm  <= rt[DIST_W-1:0];
    end
  end

  // checks
  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    fire && at_last |=> pos == '0 && seen == '0)
    else $error("scan state not cleared after last sample");

  a_cmd_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(commands.valid) |-> $past(fire && at_last))
    else $error("command raised without a last-sample beat");

  a_backup_speed: assert property (@(posedge clk) disable iff (rst)
    commands.valid |-> (commands.action == ACT_BACKUP) ==
                       (commands.linear_speed == LIN_BACKUP))
    else $error("backup action and speed disagree");

  a_forward_speed: assert property (@(posedge clk) disable iff (rst)
    commands.valid |-> (commands.action == ACT_FORWARD) ==
                       (commands.linear_speed == LIN_FORWARD))
    else $error("forward action and speed disagree");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lidar_sector_obstacle_avoider.
// ----------------------------------------------------------------------------
// A directed stimulus table covers reset values, out-of-range scan lengths,
// unmapped register writes, invalid and all-ones ranges, and a scan shrunk
// partway through. Randomized scans then follow under many register settings.
// A behavioral model of sector minima and drive rule predicts each command no
// directed row fixes. Both channels idle at random, but for one full-rate run.
// ----------------------------------------------------------------------------
module tb;
  import lsoa_pkg::*;

  localparam int MAX_SCAN     = 4096;
  localparam int SETTLE       = 4;
  localparam int RANDOM_ITEMS = 800;
  localparam int MIN_COMMANDS = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic signed [SPEED_W-1:0] lin;
    logic signed [SPEED_W-1:0] ang;
    action_t                   act;
    logic [DIST_W-1:0]         front_mm;
    logic [DIST_W-1:0]         left_mm;
    logic [DIST_W-1:0]         right_mm;
  } drive_cmd_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;
    logic [DIST_W-1:0]       range_mm;
    logic                    not_finite;
    bit                      typed;
    drive_cmd_t              cmd;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  lsoa_sample_if #(.RANGE_BITS(16)) smp_if ();
  lsoa_command_if                   cmd_if ();

  lidar_sector_obstacle_avoider #(
    .MAX_SCAN  (MAX_SCAN),
    .RANGE_BITS(16)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .samples  (smp_if),
    .commands (cmd_if)
  );

  always #4 clk = ~clk;

  // register mirror
  logic [SCAN_LEN_W-1:0] scan_len_cfg;
  logic [DIST_W-1:0]     stop_mm;
  logic [DIST_W-1:0]     backup_mm;
  logic [DIST_W-1:0]     side_mm;
  logic [DIST_W-1:0]     empty_mm;

  // scan state
  int                scan_pos;
  logic [DIST_W-1:0] right_near;
  logic [DIST_W-1:0] front_near;
  logic [DIST_W-1:0] left_near;
  logic [2:0]        sectors_seen;

  drive_cmd_t expected_cmds[$];
  stim_row_t  stim_table[$];

  bit steady = 1'b0;
  int n_fail = 0;
  int n_samples = 0;
  int n_cmds = 0;
  int n_settings = 0;
  int n_long = 0;
  int action_hits[6];

  function automatic drive_cmd_t mk_cmd(input int lin, input int ang, input action_t act,
                                        input logic [DIST_W-1:0] f,
                                        input logic [DIST_W-1:0] l,
                                        input logic [DIST_W-1:0] r);
    drive_cmd_t c;
    c.lin = SPEED_W'(lin);
    c.ang = SPEED_W'(ang);
    c.act = act;
    c.front_mm = f;
    c.left_mm = l;
    c.right_mm = r;
    return c;
  endfunction

  function automatic int eff_scan_len();
    int n;
    n = int'(scan_len_cfg);
    if (n == 0) n = 1;
    if (n > MAX_SCAN) n = MAX_SCAN;
    return n;
  endfunction

  function automatic void clear_scan();
    scan_pos = 0;
    right_near = '1;
    front_near = '1;
    left_near = '1;
    sectors_seen = '0;
  endfunction

  // Folds one accepted sample into the sector minima; returns 1 at scan end.
  function automatic bit fold_sample(input logic [DIST_W-1:0] r, input logic nf,
                                     output drive_cmd_t cmd);
    int n;
    int p;
    logic [DIST_W-1:0] f;
    logic [DIST_W-1:0] l;
    logic [DIST_W-1:0] rt;
    n = eff_scan_len();
    p = scan_pos;
    cmd = '0;
    if (!nf && r != '0) begin
      if (p >= n / 8 && p < (3 * n) / 8) begin
        if (r < right_near) right_near = r;
        sectors_seen[0] = 1'b1;
      end else if (p >= (3 * n) / 8 && p < (5 * n) / 8) begin
        if (r < front_near) front_near = r;
        sectors_seen[1] = 1'b1;
      end else if (p >= (5 * n) / 8 && p < (7 * n) / 8) begin
        if (r < left_near) left_near = r;
        sectors_seen[2] = 1'b1;
      end
    end
    if (p + 1 < n) begin
      scan_pos = p + 1;
      return 1'b0;
    end
    rt = sectors_seen[0] ? right_near : empty_mm;
    f  = sectors_seen[1] ? front_near : empty_mm;
    l  = sectors_seen[2] ? left_near  : empty_mm;
    if (f < backup_mm) begin
      cmd = mk_cmd(-150, 0, ACT_BACKUP, f, l, rt);
    end else if (f < stop_mm) begin
      if (l > rt) cmd = mk_cmd(0, 500, ACT_SPIN_LEFT, f, l, rt);
      else        cmd = mk_cmd(0, -500, ACT_SPIN_RIGHT, f, l, rt);
    end else if (rt < side_mm) begin
      cmd = mk_cmd(100, 300, ACT_VEER_LEFT, f, l, rt);
    end else if (l < side_mm) begin
      cmd = mk_cmd(100, -300, ACT_VEER_RIGHT, f, l, rt);
    end else begin
      cmd = mk_cmd(300, 0, ACT_FORWARD, f, l, rt);
    end
    clear_scan();
    return 1'b1;
  endfunction

  function automatic stim_row_t wr_row(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    stim_row_t s;
    s = '{ROW_WRITE, idx, val, '0, 1'b0, 1'b0, '0};
    return s;
  endfunction

  function automatic stim_row_t smp_row(input logic [DIST_W-1:0] r, input logic nf);
    stim_row_t s;
    s = '{ROW_SAMPLE, '0, '0, r, nf, 1'b0, '0};
    return s;
  endfunction

  function automatic stim_row_t chk_row(input logic [DIST_W-1:0] r, input logic nf,
                                        input drive_cmd_t c);
    stim_row_t s;
    s = '{ROW_SAMPLE, '0, '0, r, nf, 1'b1, c};
    return s;
  endfunction

  // Writes one register once no command is outstanding and the pipe has drained.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    smp_if.valid = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SCAN_LENGTH:     scan_len_cfg = val[SCAN_LEN_W-1:0];
      CFG_STOP_DISTANCE:   stop_mm = val;
      CFG_BACKUP_DISTANCE: backup_mm = val;
      CFG_SIDE_DISTANCE:   side_mm = val;
      CFG_EMPTY_SECTOR:    empty_mm = val;
      default: ;
    endcase
  endtask

  // Presents one sample beat; on acceptance records any command it completes.
  task automatic send_sample(input logic [DIST_W-1:0] r, input logic nf,
                             input bit typed, input drive_cmd_t typed_cmd);
    drive_cmd_t c;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 26) begin
      smp_if.valid = 1'b0;
      smp_if.range_mm = 16'($urandom);
      smp_if.not_finite = 1'($urandom);
      @(negedge clk);
    end
    smp_if.valid = 1'b1;
    smp_if.range_mm = r;
    smp_if.not_finite = nf;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    n_samples++;
    if (fold_sample(r, nf, c)) expected_cmds.push_back(typed ? typed_cmd : c);
  endtask

  function automatic logic [DIST_W-1:0] pick_range();
    case ($urandom_range(19))
      0, 1:    return '0;
      2:       return '1;
      3, 4, 5: return 16'($urandom);
      default: return 16'($urandom_range(2000, 1));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] pick_dist(input int hi);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(hi, 0));
    endcase
  endfunction

  task automatic reprogram();
    logic [SCAN_LEN_W-1:0] len;
    case ($urandom_range(19))
      0:       len = '0;
      1:       len = (n_long < 2) ? 13'($urandom_range(8191, MAX_SCAN + 1)) : 13'd8;
      2:       len = 13'd360;
      3:       len = (n_long < 2) ? 13'(MAX_SCAN) : 13'd16;
      default: len = 13'($urandom_range(40, 1));
    endcase
    write_reg(CFG_SCAN_LENGTH, {3'($urandom), len});
    if (eff_scan_len() > 360) n_long++;
    if ($urandom_range(9) < 6) write_reg(CFG_STOP_DISTANCE, pick_dist(1200));
    if ($urandom_range(9) < 6) write_reg(CFG_BACKUP_DISTANCE, pick_dist(600));
    if ($urandom_range(9) < 6) write_reg(CFG_SIDE_DISTANCE, pick_dist(1000));
    if ($urandom_range(9) < 4) write_reg(CFG_EMPTY_SECTOR, pick_dist(8000));
    if ($urandom_range(9) == 0) write_reg(CFG_UNMAPPED_LO + 3'($urandom_range(2)), '1);
    n_settings++;
  endtask

  always @(negedge clk) begin
    cmd_if.ready <= !rst && (steady || $urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      n_cmds++;
      if (int'(cmd_if.action) < 6) action_hits[int'(cmd_if.action)]++;
      if (expected_cmds.size() == 0) begin
        $error("unexpected command beat: action %0d", cmd_if.action);
        n_fail++;
      end else begin
        want = expected_cmds.pop_front();
        if (cmd_if.linear_speed !== want.lin) begin
          $error("linear_speed: expected %0d, got %0d", want.lin, cmd_if.linear_speed);
          n_fail++;
        end
        if (cmd_if.angular_speed !== want.ang) begin
          $error("angular_speed: expected %0d, got %0d", want.ang, cmd_if.angular_speed);
          n_fail++;
        end
        if (cmd_if.action !== want.act) begin
          $error("action: expected %0d, got %0d", want.act, cmd_if.action);
          n_fail++;
        end
        if (cmd_if.front_min_mm !== want.front_mm) begin
          $error("front_min_mm: expected %0d, got %0d", want.front_mm, cmd_if.front_min_mm);
          n_fail++;
        end
        if (cmd_if.left_min_mm !== want.left_mm) begin
          $error("left_min_mm: expected %0d, got %0d", want.left_mm, cmd_if.left_min_mm);
          n_fail++;
        end
        if (cmd_if.right_min_mm !== want.right_mm) begin
          $error("right_min_mm: expected %0d, got %0d", want.right_mm, cmd_if.right_min_mm);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    drive_cmd_t fwd_empty;
    drive_cmd_t backup_zero;
    int phase;
    int n;
    int count;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    smp_if.valid = 1'b0;
    smp_if.range_mm = '0;
    smp_if.not_finite = 1'b0;
    cmd_if.ready = 1'b0;
    scan_len_cfg = SCAN_LENGTH_RESET;
    stop_mm = STOP_DISTANCE_RESET;
    backup_mm = BACKUP_DISTANCE_RESET;
    side_mm = SIDE_DISTANCE_RESET;
    empty_mm = EMPTY_SECTOR_RESET;
    clear_scan();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    fwd_empty = mk_cmd(300, 0, ACT_FORWARD, 16'd5000, 16'd5000, 16'd5000);
    backup_zero = mk_cmd(-150, 0, ACT_BACKUP, '0, '0, '0);

    // one-sample scans: no sector is ever hit
    stim_table.push_back(wr_row(CFG_SCAN_LENGTH, 16'd1));
    stim_table.push_back(chk_row(16'd0, 1'b0, fwd_empty));
    stim_table.push_back(chk_row(16'hFFFF, 1'b1, fwd_empty));
    stim_table.push_back(wr_row(CFG_SCAN_LENGTH, 16'd0));
    stim_table.push_back(chk_row(16'd1234, 1'b0, fwd_empty));
    stim_table.push_back(wr_row(CFG_EMPTY_SECTOR, 16'd0));
    stim_table.push_back(chk_row(16'd7, 1'b0, backup_zero));
    stim_table.push_back(wr_row(CFG_UNMAPPED_LO, 16'hFFFF));
    stim_table.push_back(wr_row(CFG_UNMAPPED_HI, 16'hFFFF));
    stim_table.push_back(chk_row(16'd1, 1'b0, backup_zero));
    // eight-sample scan: all-ones range, zero and non-finite readings
    stim_table.push_back(wr_row(CFG_EMPTY_SECTOR, 16'hFFFF));
    stim_table.push_back(wr_row(CFG_SCAN_LENGTH, 16'd8));
    stim_table.push_back(smp_row(16'd1, 1'b0));
    stim_table.push_back(smp_row(16'hFFFF, 1'b0));
    stim_table.push_back(smp_row(16'd0, 1'b0));
    stim_table.push_back(smp_row(16'd600, 1'b1));
    stim_table.push_back(smp_row(16'hFFFF, 1'b0));
    stim_table.push_back(smp_row(16'd400, 1'b0));
    stim_table.push_back(smp_row(16'd0, 1'b1));
    stim_table.push_back(smp_row(16'd5, 1'b0));
    // shrink the scan past the current position
    stim_table.push_back(smp_row(16'd100, 1'b0));
    stim_table.push_back(smp_row(16'd200, 1'b0));
    stim_table.push_back(smp_row(16'd300, 1'b0));
    stim_table.push_back(smp_row(16'd50, 1'b0));
    stim_table.push_back(smp_row(16'd800, 1'b0));
    stim_table.push_back(wr_row(CFG_SCAN_LENGTH, 16'd3));
    stim_table.push_back(smp_row(16'd900, 1'b0));

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        write_reg(stim_table[i].index, stim_table[i].data);
      end else begin
        send_sample(stim_table[i].range_mm, stim_table[i].not_finite,
                    stim_table[i].typed, stim_table[i].cmd);
      end
    end

    phase = 0;
    while (n_samples < RANDOM_ITEMS || n_cmds < MIN_COMMANDS) begin
      phase++;
      steady = (phase >= 5 && phase < 9);
      reprogram();
      n = eff_scan_len();
      // long scans run partway; a later shorter length ends them early
      count = (n > 64) ? $urandom_range(64, 1) : n * $urandom_range(4, 1);
      if (n > 1 && n <= 64 && $urandom_range(9) < 3) count += $urandom_range(n - 1, 1);
      for (int k = 0; k < count; k++) begin
        send_sample(pick_range(), ($urandom_range(9) == 0), 1'b0, '0);
      end
    end

    @(negedge clk);
    smp_if.valid = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE * 4) @(posedge clk);
    if (expected_cmds.size() != 0) begin
      $error("%0d commands never arrived", expected_cmds.size());
      n_fail++;
    end
    $display("Run: %0d samples, %0d commands, %0d register settings, %0d failures",
             n_samples, n_cmds, n_settings, n_fail);
    $display("Actions: backup %0d, spin L/R %0d/%0d, veer L/R %0d/%0d, forward %0d",
             action_hits[0], action_hits[1], action_hits[2], action_hits[3],
             action_hits[4], action_hits[5]);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lsoa_pkg.sv
hw/rtl/lsoa_sample_if.sv
hw/rtl/lsoa_command_if.sv
hw/rtl/lidar_sector_obstacle_avoider.sv
test/tb.sv
